/* rtl/psi_pkg.sv */
// Shared constants and types for the sorted priority queue.
package psi_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] elem;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

/* rtl/psi_cell.sv */
// One slot of the sorted chain: compare against the pushed entry and shift on push or pop.
module psi_cell (
  input  logic              clk,
  input  psi_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  psi_pkg::entry_t   new_entry,
  input  psi_pkg::entry_t   left_q,
  input  logic              left_stays,
  input  psi_pkg::entry_t   right_q,
  output psi_pkg::entry_t   data_q,
  output psi_pkg::entry_t   data_nxt,
  output logic              stays
);
  import psi_pkg::*;

  entry_t data_r;

  assign stays = occupied && (data_r.prio > new_entry.prio);

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      if (!stays) begin
        data_nxt = left_stays ? new_entry : left_q;
      end
    end else if (ctl.pop) begin
      data_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

/* rtl/priority_stack_sorted_insert_top.sv */
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
//
// Input channel: in_valid/in_stall carry one request (in_kind, in_elem, in_prio).
// A push inserts the entry ahead of the first stored entry whose priority is
// less than or equal to its own, so equal priorities leave last-in first-out;
// a pop removes the front entry. Every request yields exactly one result on
// out_valid/out_stall: front element and priority (zero when empty), count,
// empty flag and status (ok, push dropped when full, pop on empty).
// The result is registered and appears in the cycle after acceptance. Throughput
// is one request per cycle unless a result waits under out_stall; all cells compare
// and shift in parallel in the same cycle, so the chain length does not add cycles.
// The result register is the only buffer: while a result waits under
// out_stall, in_stall is raised and the queue holds its contents.
// Reset empties the queue (count zero) and clears the result valid; slot
// contents are not cleared and are never shown before being written.
module priority_stack_sorted_insert_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [psi_pkg::ELEM_BITS-1:0] in_elem,
  input  logic [psi_pkg::PRIO_BITS-1:0] in_prio,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psi_pkg::ELEM_BITS-1:0] out_front_elem,
  output logic [psi_pkg::PRIO_BITS-1:0] out_front_prio,
  output logic [psi_pkg::CNT_BITS-1:0]  out_count,
  output logic                          out_is_empty,
  output logic [1:0]                    out_status
);
  import psi_pkg::*;

  logic                 accept;
  logic                 is_full;
  logic                 is_none;
  cell_ctl_t            ctl;
  entry_t               new_entry;
  entry_t               cell_q   [CAPACITY];
  entry_t               cell_d   [CAPACITY];
  logic                 cell_stay[CAPACITY];
  logic [CNT_BITS-1:0]  fill_r, fill_nxt;
  status_t              status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ELEM_BITS-1:0] out_elem_r;
  logic [PRIO_BITS-1:0] out_prio_r;
  logic [CNT_BITS-1:0]  out_count_r;
  logic                 out_empty_r;
  status_t              out_status_r;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_full   = (fill_r == CNT_BITS'(CAPACITY));
  assign is_none   = (fill_r == '0);
  assign new_entry = '{elem: in_elem, prio: in_prio};

  always_comb begin
    ctl.push   = accept && (kind_t'(in_kind) == KIND_PUSH) && !is_full;
    ctl.pop    = accept && (kind_t'(in_kind) == KIND_POP) && !is_none;
    fill_nxt   = fill_r;
    status_nxt = ST_OK;
    if (ctl.push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.pop) begin
      fill_nxt = fill_r - 1'b1;
    end
    if (kind_t'(in_kind) == KIND_PUSH) begin
      if (is_full) status_nxt = ST_FULL;
    end else begin
      if (is_none) status_nxt = ST_EMPTY;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_q;
    logic   left_stays;
    entry_t right_q;

    if (i == 0) begin : g_head
      assign left_q     = new_entry;
      assign left_stays = 1'b1;
    end else begin : g_body
      assign left_q     = cell_q[i-1];
      assign left_stays = cell_stay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_q = cell_q[i];
    end else begin : g_mid
      assign right_q = cell_q[i+1];
    end

    psi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_BITS'(i) < fill_r),
      .new_entry  (new_entry),
      .left_q     (left_q),
      .left_stays (left_stays),
      .right_q    (right_q),
      .data_q     (cell_q[i]),
      .data_nxt   (cell_d[i]),
      .stays      (cell_stay[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_elem_r   <= (fill_nxt != '0) ? cell_d[0].elem : '0;
      out_prio_r   <= (fill_nxt != '0) ? cell_d[0].prio : '0;
      out_count_r  <= fill_nxt;
      out_empty_r  <= (fill_nxt == '0);
      out_status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_front_elem = out_elem_r;
  assign out_front_prio = out_prio_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_empty_r;
  assign out_status     = out_status_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_BITS'(CAPACITY))
    else $error("fill exceeds capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> out_count_r == CNT_BITS'(CAPACITY))
    else $error("full status with non-full count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> fill_r == $past(fill_r) - 1'b1)
    else $error("pop did not shrink the queue");

  a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r >= CNT_BITS'(2) |-> cell_q[0].prio >= cell_q[1].prio)
    else $error("front entries out of order");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !ctl.push && !ctl.pop)
    else $error("queue changed while result stalled");

endmodule

/* verif/tb_top.sv */
// Testbench for the sorted priority queue: directed and random requests, scoreboard check.
module tb_top;
  import psi_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic [ELEM_BITS-1:0] elem;
    logic [PRIO_BITS-1:0] prio;
  } request_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] front_elem;
    logic [PRIO_BITS-1:0] front_prio;
    logic [CNT_BITS-1:0]  count;
    logic                 is_empty;
    status_t              status;
  } queue_view_t;

  class queue_scoreboard;
    entry_t      slots[CAPACITY];
    int          fill;
    queue_view_t pending_views[$];
    int          mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the shadow queue and queue the view it leaves.
    function void note_request(request_t req);
      queue_view_t view;
      status_t     st;
      int          pos;
      int          i;
      st = ST_OK;
      if (req.kind == KIND_PUSH) begin
        if (fill >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill && slots[pos].prio > req.prio) pos++;
          for (i = fill; i > pos; i--) slots[i] = slots[i-1];
          slots[pos].elem = req.elem;
          slots[pos].prio = req.prio;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 1; i < fill; i++) slots[i-1] = slots[i];
          fill--;
        end
      end
      view.front_elem = (fill > 0) ? slots[0].elem : '0;
      view.front_prio = (fill > 0) ? slots[0].prio : '0;
      view.count      = fill[CNT_BITS-1:0];
      view.is_empty   = (fill == 0);
      view.status     = st;
      pending_views.push_back(view);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(queue_view_t seen);
      queue_view_t want;
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, seen);
        mismatches++;
        return;
      end
      want = pending_views.pop_front();
      compare_field("front_elem", 64'(want.front_elem), 64'(seen.front_elem));
      compare_field("front_prio", 64'(want.front_prio), 64'(seen.front_prio));
      compare_field("count", 64'(want.count), 64'(seen.count));
      compare_field("is_empty", 64'(want.is_empty), 64'(seen.is_empty));
      compare_field("status", 64'(want.status), 64'(seen.status));
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 in_kind   = 1'b0;
  logic [ELEM_BITS-1:0] in_elem   = '0;
  logic [PRIO_BITS-1:0] in_prio   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ELEM_BITS-1:0] out_front_elem;
  logic [PRIO_BITS-1:0] out_front_prio;
  logic [CNT_BITS-1:0]  out_count;
  logic                 out_is_empty;
  logic [1:0]           out_status;

  int              send_idle_pct  = 13;
  int              recv_stall_pct = 86;
  queue_scoreboard sb             = new();
  queue_view_t     seen_view;

  priority_stack_sorted_insert_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_elem        (in_elem),
    .in_prio        (in_prio),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_front_elem (out_front_elem),
    .out_front_prio (out_front_prio),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_view.front_elem = out_front_elem;
        seen_view.front_prio = out_front_prio;
        seen_view.count      = out_count;
        seen_view.is_empty   = out_is_empty;
        seen_view.status     = status_t'(out_status);
        sb.check_result(seen_view);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= req.kind;
    in_elem  <= req.elem;
    in_prio  <= req.prio;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic send_fields(kind_t kind, logic [ELEM_BITS-1:0] elem,
                             logic [PRIO_BITS-1:0] prio);
    request_t req;
    req.kind = kind;
    req.elem = elem;
    req.prio = prio;
    send_request(req);
  endtask

  function automatic request_t random_request(int push_pct);
    request_t req;
    req.kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
    req.elem = $urandom;
    case ($urandom_range(3))
      0: req.prio = PRIO_BITS'($urandom_range(3));
      1: req.prio = 8'hFC | PRIO_BITS'($urandom_range(3));
      default: req.prio = PRIO_BITS'($urandom);
    endcase
    return req;
  endfunction

  initial begin
    int phase;
    int n;
    int push_pct;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on empty, priority extremes, equal priorities, fill to full
    send_fields(KIND_POP, 32'hFFFF_FFFF, 8'hFF);
    send_fields(KIND_PUSH, 32'h0000_0000, 8'h00);
    send_fields(KIND_PUSH, 32'hFFFF_FFFF, 8'hFF);
    send_fields(KIND_PUSH, 32'hA5A5_A5A5, 8'hFF);
    send_fields(KIND_PUSH, 32'h5A5A_5A5A, 8'h00);
    for (n = 0; n < 12; n++) begin
      send_fields(KIND_PUSH, ELEM_BITS'(32'h1234_5678 ^ (n * 32'h1111_1111)),
                  PRIO_BITS'(n * 23));
    end
    send_fields(KIND_PUSH, 32'hDEAD_BEEF, 8'hFF);
    send_fields(KIND_POP, 32'h0, 8'h0);
    send_fields(KIND_POP, 32'hFFFF_FFFF, 8'h80);
    send_fields(KIND_POP, 32'h0F0F_0F0F, 8'h7F);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 13; recv_stall_pct = 86; end
        1: begin send_idle_pct = 86; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      push_pct = 75;
      for (n = 0; n < 250; n++) begin
        // swing between filling and draining
        if (n % 32 == 0) push_pct = (push_pct == 75) ? 30 : 75;
        send_request(random_request(push_pct));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
